FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge outside reset.
`define SCEC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");
// Checks that a condition never holds outside reset.
`define SCEC_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SCEC_ASSERT(name, clk, rst_n, prop)
`define SCEC_NEVER(name, clk, rst_n, expr)
`endif
`endif

FILE: src/scec_pkg.sv
package scec_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W = 23;
	localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(40960);
	localparam int TOL_LSB = 4;
	localparam int TOL_W = $clog2(TOL_LSB + 1);
	localparam int TFRAC = 30;
	localparam int FRAC_W = TFRAC + 1;

	localparam int DIFF_W = COORD_W + 1;
	localparam int SQR_W = 2 * DIFF_W;
	localparam int HALF_W = SQR_W / 2;
	localparam int R2_W = 2 * RAD_W;
	localparam int RH_W = R2_W / 2;
	localparam int REACH_W = RAD_W + 1;
	localparam int WIDE_W = 2 * SQR_W;
	localparam int RADICAND_W = SQR_W + R2_W;
	localparam int ROOT_W = RADICAND_W / 2;
	localparam int ND_W = SQR_W + 1;
	localparam int CAND_W = ND_W + 1;

	localparam int PADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_RADIUS = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
	} seg_in_t;

	typedef struct packed {
		logic piece_valid;
		logic signed [COORD_W-1:0] piece_start_x;
		logic signed [COORD_W-1:0] piece_start_y;
		logic signed [COORD_W-1:0] piece_end_x;
		logic signed [COORD_W-1:0] piece_end_y;
		logic segment_changed;
		logic last_piece;
	} piece_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} seg_t;

	// Per-item side information that travels with the root solver.
	typedef struct packed {
		seg_t seg;
		logic in_start;
		logic in_end;
		logic [SQR_W-1:0] a;
		logic signed [ND_W-1:0] nd;
		logic disc_ok;
	} carry_t;

endpackage

FILE: src/scec_front.sv
module scec_front import scec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  seg_in_t in_data,
	input  logic [RAD_W-1:0] radius,
	output logic out_valid,
	output carry_t out_carry,
	output logic [RADICAND_W-1:0] out_disc
);

	logic [REACH_W-1:0] reach;
	assign reach = REACH_W'(radius) + REACH_W'(TOL_LSB);

	// Stage 1: differences and radius squares.
	logic v_s1;
	seg_t seg_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, px_s1, py_s1, qx_s1, qy_s1;
	logic [R2_W-1:0] r2_s1;
	logic [2*REACH_W-1:0] reach2_s1;

	// Stage 2: products.
	logic v_s2;
	seg_t seg_s2;
	logic signed [SQR_W-1:0] dxx_s2, dyy_s2, pxdy_s2, pydx_s2, pxdx_s2, pydy_s2;
	logic signed [SQR_W-1:0] pxx_s2, pyy_s2, qxx_s2, qyy_s2;
	logic [R2_W-1:0] r2_s2;
	logic [2*REACH_W-1:0] reach2_s2;

	// Stage 3: sums and endpoint tests.
	logic v_s3;
	carry_t c_s3;
	logic [SQR_W-1:0] crm_s3;
	logic [R2_W-1:0] r2_s3;

	// Stage 4: partial products of cr^2 and a*r^2.
	logic v_s4;
	carry_t c_s4;
	logic [2*HALF_W-1:0] hh_s4, hl_s4, ll_s4;
	logic [HALF_W+RH_W-1:0] ahrh_s4, ahrl_s4, alrh_s4, alrl_s4;

	// Stage 5: full products.
	logic v_s5;
	carry_t c_s5;
	logic [WIDE_W-1:0] c2_s5, ar2_s5;

	// Stage 6: discriminant.
	logic v_s6;
	carry_t c_s6;
	logic [RADICAND_W-1:0] disc_s6;

	logic signed [ND_W-1:0] cr_w, nd_w;
	logic [SQR_W-1:0] d_start_w, d_end_w, a_w;
	carry_t c6_w;

	always_comb begin
		cr_w = ND_W'(pxdy_s2) - ND_W'(pydx_s2);
		nd_w = -(ND_W'(pxdx_s2) + ND_W'(pydy_s2));
		a_w = $unsigned(dxx_s2) + $unsigned(dyy_s2);
		d_start_w = $unsigned(pxx_s2) + $unsigned(pyy_s2);
		d_end_w = $unsigned(qxx_s2) + $unsigned(qyy_s2);
		c6_w = c_s5;
		c6_w.disc_ok = c_s5.disc_ok && (ar2_s5 >= c2_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= '{start_x: in_data.start_x, start_y: in_data.start_y,
				end_x: in_data.end_x, end_y: in_data.end_y};
			dx_s1 <= DIFF_W'(in_data.end_x) - DIFF_W'(in_data.start_x);
			dy_s1 <= DIFF_W'(in_data.end_y) - DIFF_W'(in_data.start_y);
			px_s1 <= DIFF_W'(in_data.start_x) - DIFF_W'(in_data.center_x);
			py_s1 <= DIFF_W'(in_data.start_y) - DIFF_W'(in_data.center_y);
			qx_s1 <= DIFF_W'(in_data.end_x) - DIFF_W'(in_data.center_x);
			qy_s1 <= DIFF_W'(in_data.end_y) - DIFF_W'(in_data.center_y);
			r2_s1 <= R2_W'(radius) * R2_W'(radius);
			reach2_s1 <= (2*REACH_W)'(reach) * (2*REACH_W)'(reach);

			seg_s2 <= seg_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			pxdy_s2 <= px_s1 * dy_s1;
			pydx_s2 <= py_s1 * dx_s1;
			pxdx_s2 <= px_s1 * dx_s1;
			pydy_s2 <= py_s1 * dy_s1;
			pxx_s2 <= px_s1 * px_s1;
			pyy_s2 <= py_s1 * py_s1;
			qxx_s2 <= qx_s1 * qx_s1;
			qyy_s2 <= qy_s1 * qy_s1;
			r2_s2 <= r2_s1;
			reach2_s2 <= reach2_s1;

			c_s3 <= '{seg: seg_s2,
				in_start: (d_start_w <= SQR_W'(reach2_s2)),
				in_end: (d_end_w <= SQR_W'(reach2_s2)),
				a: a_w,
				nd: nd_w,
				disc_ok: (a_w != '0)};
			crm_s3 <= cr_w[ND_W-1] ? SQR_W'(-cr_w) : SQR_W'(cr_w);
			r2_s3 <= r2_s2;

			c_s4 <= c_s3;
			hh_s4 <= (2*HALF_W)'(crm_s3[SQR_W-1:HALF_W])
				* (2*HALF_W)'(crm_s3[SQR_W-1:HALF_W]);
			hl_s4 <= (2*HALF_W)'(crm_s3[SQR_W-1:HALF_W])
				* (2*HALF_W)'(crm_s3[HALF_W-1:0]);
			ll_s4 <= (2*HALF_W)'(crm_s3[HALF_W-1:0])
				* (2*HALF_W)'(crm_s3[HALF_W-1:0]);
			ahrh_s4 <= (HALF_W+RH_W)'(c_s3.a[SQR_W-1:HALF_W])
				* (HALF_W+RH_W)'(r2_s3[R2_W-1:RH_W]);
			ahrl_s4 <= (HALF_W+RH_W)'(c_s3.a[SQR_W-1:HALF_W])
				* (HALF_W+RH_W)'(r2_s3[RH_W-1:0]);
			alrh_s4 <= (HALF_W+RH_W)'(c_s3.a[HALF_W-1:0])
				* (HALF_W+RH_W)'(r2_s3[R2_W-1:RH_W]);
			alrl_s4 <= (HALF_W+RH_W)'(c_s3.a[HALF_W-1:0])
				* (HALF_W+RH_W)'(r2_s3[RH_W-1:0]);

			c_s5 <= c_s4;
			c2_s5 <= (WIDE_W'(hh_s4) << (2*HALF_W)) + (WIDE_W'(hl_s4) << (HALF_W+1))
				+ WIDE_W'(ll_s4);
			ar2_s5 <= (WIDE_W'(ahrh_s4) << (HALF_W+RH_W)) + (WIDE_W'(ahrl_s4) << HALF_W)
				+ (WIDE_W'(alrh_s4) << RH_W) + WIDE_W'(alrl_s4);

			c_s6 <= c6_w;
			disc_s6 <= RADICAND_W'(ar2_s5 - c2_s5);
		end
	end

	assign out_valid = v_s6;
	assign out_carry = c_s6;
	assign out_disc = disc_s6;

endmodule

FILE: src/scec_isqrt.sv
module scec_isqrt import scec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  carry_t in_carry,
	input  logic [RADICAND_W-1:0] in_disc,
	output logic out_valid,
	output carry_t out_carry,
	output logic [ROOT_W-1:0] out_root
);

	localparam int REM_W = RADICAND_W + 1;

	// One result bit per stage, most significant first. The remainder holds
	// the radicand minus the square of the root found so far.
	logic v_s [ROOT_W];
	carry_t c_s [ROOT_W];
	logic [REM_W-1:0] rem_s [ROOT_W];
	logic [ROOT_W-1:0] x_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
		localparam int B = ROOT_W - 1 - i;
		logic [REM_W-1:0] rem_in, trial;
		logic [ROOT_W-1:0] x_in;
		logic v_in;
		carry_t c_in;

		if (i == 0) begin : g_head
			assign rem_in = {1'b0, in_disc};
			assign x_in = '0;
			assign v_in = in_valid;
			assign c_in = in_carry;
		end else begin : g_body
			assign rem_in = rem_s[i-1];
			assign x_in = x_s[i-1];
			assign v_in = v_s[i-1];
			assign c_in = c_s[i-1];
		end

		assign trial = (REM_W'(x_in) << (B + 1)) + (REM_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				c_s[i] <= c_in;
				if (rem_in >= trial) begin
					rem_s[i] <= rem_in - trial;
					x_s[i] <= x_in | (ROOT_W'(1) << B);
				end else begin
					rem_s[i] <= rem_in;
					x_s[i] <= x_in;
				end
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_carry = c_s[ROOT_W-1];
	assign out_root = x_s[ROOT_W-1];

endmodule

FILE: src/scec_divide.sv
module scec_divide import scec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  carry_t in_carry,
	input  logic [ROOT_W-1:0] in_root,
	output logic out_valid,
	output carry_t out_carry,
	output logic [1:0] out_ok,
	output logic [FRAC_W-1:0] out_frac [2]
);

	// Candidate stage: both numerators, their range checks and the
	// whole-segment case where the numerator is at least a.
	logic v_c;
	carry_t c_c;
	logic [1:0] ok_c, full_c;
	logic [SQR_W-1:0] n_c [2];

	logic signed [CAND_W-1:0] nd_w, sq_w, a_w;
	logic signed [CAND_W-1:0] cand_w [2];

	always_comb begin
		nd_w = CAND_W'(in_carry.nd);
		sq_w = CAND_W'($signed({1'b0, in_root}));
		a_w = CAND_W'($signed({1'b0, in_carry.a}));
		cand_w[0] = nd_w - sq_w;
		cand_w[1] = nd_w + sq_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= 1'b0;
		end else if (adv) begin
			v_c <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_c <= in_carry;
			for (int l = 0; l < 2; l++) begin
				ok_c[l] <= in_carry.disc_ok && !cand_w[l][CAND_W-1] && (cand_w[l] <= a_w);
				full_c[l] <= (cand_w[l] >= a_w);
				n_c[l] <= cand_w[l][SQR_W-1:0];
			end
		end
	end

	// Restoring division, one quotient bit per stage for each lane.
	logic v_s [TFRAC];
	carry_t c_s [TFRAC];
	logic [1:0] ok_s [TFRAC];
	logic [1:0] full_s [TFRAC];
	logic [SQR_W-1:0] n_s [TFRAC][2];
	logic [TFRAC-1:0] q_s [TFRAC][2];

	for (genvar i = 0; i < TFRAC; i++) begin : g_step
		logic v_in;
		carry_t c_in;
		logic [1:0] ok_in, full_in;
		logic [SQR_W-1:0] n_in [2];
		logic [TFRAC-1:0] q_in [2];
		logic [SQR_W:0] sh [2];
		logic [1:0] ge;

		if (i == 0) begin : g_head
			assign v_in = v_c;
			assign c_in = c_c;
			assign ok_in = ok_c;
			assign full_in = full_c;
			assign n_in = n_c;
			assign q_in = '{default: '0};
		end else begin : g_body
			assign v_in = v_s[i-1];
			assign c_in = c_s[i-1];
			assign ok_in = ok_s[i-1];
			assign full_in = full_s[i-1];
			assign n_in = n_s[i-1];
			assign q_in = q_s[i-1];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				sh[l] = {n_in[l], 1'b0};
				ge[l] = (sh[l] >= {1'b0, c_in.a});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				c_s[i] <= c_in;
				ok_s[i] <= ok_in;
				full_s[i] <= full_in;
				for (int l = 0; l < 2; l++) begin
					n_s[i][l] <= ge[l] ? SQR_W'(sh[l] - {1'b0, c_in.a}) : SQR_W'(sh[l]);
					q_s[i][l] <= {q_in[l][TFRAC-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid = v_s[TFRAC-1];
	assign out_carry = c_s[TFRAC-1];
	assign out_ok = ok_s[TFRAC-1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			out_frac[l] = full_s[TFRAC-1][l] ? (FRAC_W'(1) << TFRAC)
				: {1'b0, q_s[TFRAC-1][l]};
		end
	end

endmodule

FILE: src/scec_back.sv
`include "assert_macros.svh"

module scec_back import scec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  carry_t in_carry,
	input  logic [1:0] in_ok,
	input  logic [FRAC_W-1:0] in_frac [2],
	input  logic out_ready,
	output logic out_valid,
	output piece_out_t out_data,
	output logic adv
);

	localparam int PROD_W = COORD_W + FRAC_W;
	localparam int QW = PROD_W - TFRAC;
	localparam int LERP_W = COORD_W + 3;
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	function automatic logic signed [COORD_W-1:0] lerp_fix(
		input logic signed [COORD_W-1:0] p,
		input logic neg,
		input logic [PROD_W-1:0] m
	);
		logic [PROD_W-1:0] rnd;
		logic signed [LERP_W-1:0] q, v;
		rnd = (m + (PROD_W'(1) << (TFRAC - 1))) >> TFRAC;
		q = LERP_W'($signed({1'b0, rnd[QW-1:0]}));
		v = neg ? LERP_W'(p) - q : LERP_W'(p) + q;
		if (v > LERP_W'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (v < LERP_W'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return v[COORD_W-1:0];
	endfunction

	function automatic logic long_enough(
		input logic signed [COORD_W-1:0] ax,
		input logic signed [COORD_W-1:0] ay,
		input logic signed [COORD_W-1:0] bx,
		input logic signed [COORD_W-1:0] by
	);
		logic signed [DIFF_W-1:0] ddx, ddy;
		logic [DIFF_W-1:0] mx, my;
		logic [2*TOL_W:0] ss;
		ddx = DIFF_W'(bx) - DIFF_W'(ax);
		ddy = DIFF_W'(by) - DIFF_W'(ay);
		mx = ddx[DIFF_W-1] ? $unsigned(-ddx) : $unsigned(ddx);
		my = ddy[DIFF_W-1] ? $unsigned(-ddy) : $unsigned(ddy);
		ss = (2*TOL_W+1)'(mx[TOL_W-1:0]) * (2*TOL_W+1)'(mx[TOL_W-1:0])
			+ (2*TOL_W+1)'(my[TOL_W-1:0]) * (2*TOL_W+1)'(my[TOL_W-1:0]);
		return (mx > DIFF_W'(TOL_LSB)) || (my > DIFF_W'(TOL_LSB))
			|| (ss > (2*TOL_W+1)'(TOL_LSB * TOL_LSB));
	endfunction

	// B1: choose first and last root, direction magnitude and sign.
	logic v_s1;
	seg_t seg_s1;
	logic in_start_s1, in_end_s1;
	logic [1:0] ok_s1;
	logic [FRAC_W-1:0] tf_s1, tl_s1;
	logic [COORD_W-1:0] mdx_s1, mdy_s1;
	logic ndx_s1, ndy_s1;

	// B2: scaled directions.
	logic v_s2;
	seg_t seg_s2;
	logic in_start_s2, in_end_s2;
	logic [1:0] ok_s2;
	logic ndx_s2, ndy_s2;
	logic [PROD_W-1:0] mxf_s2, myf_s2, mxl_s2, myl_s2;

	// B3: cut points.
	logic v_s3;
	seg_t seg_s3;
	logic in_start_s3, in_end_s3;
	logic [1:0] ok_s3;
	logic signed [COORD_W-1:0] fx_s3, fy_s3, lx_s3, ly_s3;

	// B4: length tests on both candidate pieces.
	logic v_s4;
	seg_t seg_s4;
	logic in_start_s4, in_end_s4;
	logic [1:0] ok_s4;
	logic signed [COORD_W-1:0] fx_s4, fy_s4, lx_s4, ly_s4;
	logic le0_s4, le1_s4;

	logic signed [DIFF_W-1:0] dx_w, dy_w;

	always_comb begin
		dx_w = DIFF_W'(in_carry.seg.end_x) - DIFF_W'(in_carry.seg.start_x);
		dy_w = DIFF_W'(in_carry.seg.end_y) - DIFF_W'(in_carry.seg.start_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1 <= in_carry.seg;
			in_start_s1 <= in_carry.in_start;
			in_end_s1 <= in_carry.in_end;
			ok_s1 <= in_ok;
			tf_s1 <= in_ok[0] ? in_frac[0] : in_frac[1];
			tl_s1 <= in_ok[1] ? in_frac[1] : in_frac[0];
			mdx_s1 <= dx_w[DIFF_W-1] ? COORD_W'(-dx_w) : COORD_W'(dx_w);
			mdy_s1 <= dy_w[DIFF_W-1] ? COORD_W'(-dy_w) : COORD_W'(dy_w);
			ndx_s1 <= dx_w[DIFF_W-1];
			ndy_s1 <= dy_w[DIFF_W-1];

			seg_s2 <= seg_s1;
			in_start_s2 <= in_start_s1;
			in_end_s2 <= in_end_s1;
			ok_s2 <= ok_s1;
			ndx_s2 <= ndx_s1;
			ndy_s2 <= ndy_s1;
			mxf_s2 <= PROD_W'(mdx_s1) * PROD_W'(tf_s1);
			myf_s2 <= PROD_W'(mdy_s1) * PROD_W'(tf_s1);
			mxl_s2 <= PROD_W'(mdx_s1) * PROD_W'(tl_s1);
			myl_s2 <= PROD_W'(mdy_s1) * PROD_W'(tl_s1);

			seg_s3 <= seg_s2;
			in_start_s3 <= in_start_s2;
			in_end_s3 <= in_end_s2;
			ok_s3 <= ok_s2;
			fx_s3 <= lerp_fix(seg_s2.start_x, ndx_s2, mxf_s2);
			fy_s3 <= lerp_fix(seg_s2.start_y, ndy_s2, myf_s2);
			lx_s3 <= lerp_fix(seg_s2.start_x, ndx_s2, mxl_s2);
			ly_s3 <= lerp_fix(seg_s2.start_y, ndy_s2, myl_s2);

			seg_s4 <= seg_s3;
			in_start_s4 <= in_start_s3;
			in_end_s4 <= in_end_s3;
			ok_s4 <= ok_s3;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			lx_s4 <= lx_s3;
			ly_s4 <= ly_s3;
			le0_s4 <= long_enough(seg_s3.start_x, seg_s3.start_y, fx_s3, fy_s3);
			le1_s4 <= long_enough(lx_s3, ly_s3, seg_s3.end_x, seg_s3.end_y);
		end
	end

	// Piece selection. Candidate 0 runs from the start to the first cut,
	// candidate 1 from the last cut to the end.
	logic any_w, two_w, chg_w, k0_w, k1_w;
	logic [1:0] n_w;
	seg_t c0_w, c1_w, p0_w;

	always_comb begin
		any_w = ok_s4[0] | ok_s4[1];
		two_w = ok_s4[0] & ok_s4[1];
		c0_w = '{start_x: seg_s4.start_x, start_y: seg_s4.start_y,
			end_x: fx_s4, end_y: fy_s4};
		c1_w = '{start_x: lx_s4, start_y: ly_s4,
			end_x: seg_s4.end_x, end_y: seg_s4.end_y};
		unique case ({in_start_s4, in_end_s4})
			2'b00: begin
				chg_w = any_w;
				k0_w = two_w & le0_s4;
				k1_w = two_w & le1_s4;
			end
			2'b01: begin
				chg_w = any_w;
				k0_w = any_w & le0_s4;
				k1_w = 1'b0;
			end
			2'b10: begin
				chg_w = any_w;
				k0_w = 1'b0;
				k1_w = any_w & le1_s4;
			end
			default: begin
				chg_w = 1'b1;
				k0_w = 1'b0;
				k1_w = 1'b0;
			end
		endcase
		if (!chg_w) begin
			p0_w = seg_s4;
			n_w = 2'd1;
		end else begin
			p0_w = k0_w ? c0_w : c1_w;
			n_w = 2'(k0_w) + 2'(k1_w);
		end
	end

	// Output register: one item, sent as one or two words.
	logic ov_q, chg_q, ptr_q;
	logic [1:0] n_q;
	seg_t p0_q, p1_q;
	logic taken, last_w, load_ok;
	seg_t cur_w;

	assign last_w = (n_q != 2'd2) || ptr_q;
	assign taken = ov_q && out_ready;
	assign load_ok = !ov_q || (taken && last_w);
	assign adv = load_ok || !v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			ptr_q <= 1'b0;
		end else if (load_ok) begin
			ov_q <= v_s4;
			ptr_q <= 1'b0;
		end else if (taken) begin
			ptr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && v_s4) begin
			p0_q <= p0_w;
			p1_q <= c1_w;
			n_q <= n_w;
			chg_q <= chg_w;
		end
	end

	always_comb begin
		cur_w = ptr_q ? p1_q : p0_q;
		if (n_q == 2'd0) begin
			cur_w = '0;
		end
		out_data.piece_valid = (n_q != 2'd0);
		out_data.piece_start_x = cur_w.start_x;
		out_data.piece_start_y = cur_w.start_y;
		out_data.piece_end_x = cur_w.end_x;
		out_data.piece_end_y = cur_w.end_y;
		out_data.segment_changed = chg_q;
		out_data.last_piece = last_w;
	end

	assign out_valid = ov_q;

	`SCEC_NEVER(a_second_word_needs_two, clk, arst_n, ov_q && ptr_q && (n_q != 2'd2))
	`SCEC_NEVER(a_unchanged_single, clk, arst_n, ov_q && !chg_q && (n_q != 2'd1))
	`SCEC_NEVER(a_empty_is_changed, clk, arst_n, ov_q && (n_q == 2'd0) && !chg_q)
	`SCEC_ASSERT(a_drain, clk, arst_n, (taken && last_w && !v_s4) |=> !ov_q)

endmodule

FILE: src/segment_circle_eraser_clip_core.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data (seg_in_t): segment and eraser center
// out       output     out_valid / out_ready  out_data (piece_out_t): one kept piece per word
// apb       input      psel/penable, pready   paddr, pwdata, prdata: eraser_radius at 0x0
//
// One segment is taken per cycle while in_ready is high. A segment gives one or two
// output words; a two-piece segment holds the output register until both are taken.
// The path from input to first output word runs through 6 front stages, 48
// square-root stages (one root bit each), 31 divider stages (30 quotient bits),
// 4 cut-point stages and the output register.
// Reset clears all valid bits and loads the radius register with 40960.
// A stalled output freezes the whole pipeline in place, except that while the last
// pipeline stage is empty every stage keeps advancing as a word waits, so nothing is lost.
module segment_circle_eraser_clip_core import scec_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  seg_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output piece_out_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	// The radius register. A write of zero leaves the old value, since a
	// circle of radius zero would erase nothing meaningful.
	logic [RAD_W-1:0] radius_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_RESET;
		end else if (wr_en && (paddr[2] == REG_RADIUS) && (pwdata[RAD_W-1:0] != '0)) begin
			radius_q <= pwdata[RAD_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_RADIUS) ? DATA_W'(radius_q) : '0;

	// Every stage moves on the common advance signal from the output side.
	logic adv;
	assign in_ready = adv;

	logic f_valid;
	carry_t f_carry;
	logic [RADICAND_W-1:0] f_disc;

	scec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.radius   (radius_q),
		.out_valid(f_valid),
		.out_carry(f_carry),
		.out_disc (f_disc)
	);

	logic s_valid;
	carry_t s_carry;
	logic [ROOT_W-1:0] s_root;

	scec_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (f_valid),
		.in_carry (f_carry),
		.in_disc  (f_disc),
		.out_valid(s_valid),
		.out_carry(s_carry),
		.out_root (s_root)
	);

	logic d_valid;
	carry_t d_carry;
	logic [1:0] d_ok;
	logic [FRAC_W-1:0] d_frac [2];

	scec_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_valid),
		.in_carry (s_carry),
		.in_root  (s_root),
		.out_valid(d_valid),
		.out_carry(d_carry),
		.out_ok   (d_ok),
		.out_frac (d_frac)
	);

	scec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.in_carry (d_carry),
		.in_ok    (d_ok),
		.in_frac  (d_frac),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.adv      (adv)
	);

endmodule
